FILE: hdl/upl_pkg.sv
// Package for the urban-micro path loss unit: payload types and fixed constants.
`default_nettype none
package upl_pkg;

  typedef struct packed {
    logic signed [15:0] ue_x;
    logic signed [15:0] ue_y;
    logic        [9:0]  ue_z;
    logic signed [15:0] bs_x;
    logic signed [15:0] bs_y;
    logic        [9:0]  bs_z;
    logic               line_of_sight;
  } upl_in_t;

  typedef struct packed {
    logic [15:0] loss_db_q8;
    logic [2:0]  region;
  } upl_out_t;

  localparam logic [2:0] REG_LOS_NEAR = 3'd0;
  localparam logic [2:0] REG_LOS_FAR  = 3'd1;
  localparam logic [2:0] REG_NLOS     = 3'd2;
  localparam logic [2:0] REG_RANGE    = 3'd3;
  localparam logic [2:0] REG_HEIGHT   = 3'd4;

  localparam logic [9:0] CAR_RESET = 10'd250;

  // log10 results, unsigned Q16
  localparam int LOG_W = 22;
  localparam logic [22:0] LOG10_2_Q24 = 23'd5050445;

  localparam logic [63:0] D2_MIN      = 64'd10000;
  localparam logic [63:0] D2_LOS_MAX  = 64'd2500000000;
  localparam logic [63:0] D2_NLOS_MAX = 64'd400000000;
  localparam logic [63:0] BP_SCALE    = 64'd5625;

  localparam logic signed [23:0] OFS_D    = 24'sd144449;
  localparam logic signed [23:0] OFS_F    = 24'sd131072;
  localparam logic signed [23:0] OFS_BM   = 24'sd131072;

  localparam logic signed [35:0] K_NEAR = 36'sd18350080;
  localparam logic signed [35:0] K_FAR  = 36'sd5111808;
  localparam logic signed [35:0] K_NLOS = 36'sd14876672;

  localparam logic signed [35:0] DIV_RND = 36'sd1280;
  localparam logic signed [35:0] SAT_Q   = 36'sd327680;
  localparam logic [21:0]        RECIP5  = 22'd3355444;

endpackage
`default_nettype wire

FILE: hdl/upl_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module upl_sqrt #(
  parameter int N = 42
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [N-1:0]     x,
  output logic      [N/2-1:0]   y
);

  localparam int R = N / 2;

  logic [R+1:0] rem_q  [R];
  logic [R-1:0] root_q [R];
  logic [N-1:0] x_q    [R];
  logic [R+1:0] rem_n  [R];
  logic [R-1:0] root_n [R];
  logic [N-1:0] x_n    [R];

  always_comb begin
    logic [R+1:0] rin;
    logic [R+1:0] rs;
    logic [R+1:0] tr;
    logic [R-1:0] oin;
    logic [N-1:0] xin;
    rin = '0;
    rs  = '0;
    tr  = '0;
    oin = '0;
    xin = '0;
    for (int k = 0; k < R; k++) begin
      rin = (k == 0) ? '0 : rem_q[(k == 0) ? 0 : k-1];
      oin = (k == 0) ? '0 : root_q[(k == 0) ? 0 : k-1];
      xin = (k == 0) ? x : x_q[(k == 0) ? 0 : k-1];
      rs  = {rin[R-1:0], xin[N-1:N-2]};
      tr  = {oin, 2'b01};
      if (rs >= tr) begin
        rem_n[k]  = rs - tr;
        root_n[k] = {oin[R-2:0], 1'b1};
      end else begin
        rem_n[k]  = rs;
        root_n[k] = {oin[R-2:0], 1'b0};
      end
      x_n[k] = xin << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < R; k++) begin
        rem_q[k]  <= rem_n[k];
        root_q[k] <= root_n[k];
        x_q[k]    <= x_n[k];
      end
    end
  end

  assign y = root_q[R-1];

endmodule
`default_nettype wire

FILE: hdl/upl_log10.sv
// Pipelined log10 of an unsigned integer, Q16 result, by repeated squaring.
`default_nettype none
module upl_log10 #(
  parameter int XW = 10,
  parameter int FB = 8
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [XW-1:0]             x,
  output logic      [upl_pkg::LOG_W-1:0] y
);

  localparam int EW = $clog2(XW);
  localparam int LW = EW + FB;
  localparam int PW = LW + 23;

  logic [XW-1:0] xs;
  logic [EW-1:0] e0;
  logic [31:0]   m0;

  logic [31:0]   m_q [FB+1];
  logic [EW-1:0] e_q [FB+1];
  logic [FB-1:0] f_q [FB+1];
  logic [31:0]   m_n [FB];
  logic [FB-1:0] f_n [FB];
  logic [PW-1:0] prod;

  always_comb begin
    xs = (x == '0) ? XW'(1) : x;
    e0 = '0;
    for (int i = 0; i < XW; i++) begin
      if (xs[i]) e0 = EW'(i);
    end
    m0 = 32'(xs) << (6'd31 - 6'(e0));
  end

  always_comb begin
    logic [63:0] sq;
    logic [32:0] t;
    sq = '0;
    t  = '0;
    for (int k = 1; k <= FB; k++) begin
      sq = 64'(m_q[k-1]) * 64'(m_q[k-1]);
      t  = sq[63:31];
      m_n[k-1] = t[32] ? t[32:1] : t[31:0];
      f_n[k-1] = {f_q[k-1][FB-2:0], t[32]};
    end
  end

  assign prod = PW'({e_q[FB], f_q[FB]}) * PW'(upl_pkg::LOG10_2_Q24);

  always_ff @(posedge clk) begin
    if (en) begin
      m_q[0] <= m0;
      e_q[0] <= e0;
      f_q[0] <= '0;
      for (int k = 1; k <= FB; k++) begin
        m_q[k] <= m_n[k-1];
        e_q[k] <= e_q[k-1];
        f_q[k] <= f_n[k-1];
      end
      y <= upl_pkg::LOG_W'(prod >> (FB + 8));
    end
  end

endmodule
`default_nettype wire

FILE: hdl/umi_path_loss_calc.sv
// Top level of the urban-micro path loss unit: distance, breakpoint, logs, formula.
// A request passes the front stages, the square root, the log10 units and the back stages
// before its result enters the output queue.
// Throughput: one request per cycle; a two-entry output queue absorbs a stall,
// then the whole pipeline holds until a result is taken.
// Reset: pipeline valids and queue cleared, carrier register back to 2.5 GHz.
`default_nettype none
module umi_path_loss_calc #(
  parameter int COORD_BITS     = 16,
  parameter int LOG_TABLE_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire upl_pkg::upl_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output upl_pkg::upl_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [9:0]        cfg_wdata
);

  localparam int CB      = COORD_BITS;
  localparam int D2W     = 2 * CB + 2;
  localparam int SQN     = D2W + 8;
  localparam int SRW     = SQN / 2;
  localparam int LAT_LOG = LOG_TABLE_BITS + 2;
  localparam int NST     = 5 + SRW + LAT_LOG + 6;

  typedef struct packed {
    logic       los;
    logic       bad_h;
    logic       below_bp;
    logic       ge_min;
    logic       lt_los;
    logic       lt_nlos;
    logic [9:0] bm;
    logic [9:0] um;
    logic [9:0] car;
  } side_t;

  logic [9:0]     car;
  logic [NST-1:0] vld;
  logic           adv;
  logic           acc;
  logic [1:0]     cnt;
  upl_pkg::upl_out_t f0, f1;
  logic           push, pop;

  assign adv      = !(vld[NST-1] && cnt == 2'd2);
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      car <= upl_pkg::CAR_RESET;
    end else if (cfg_we) begin
      car <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], acc};
    end
  end

  // stage 1: differences, antenna height product and low-height flag
  logic [CB-1:0]      ux, uy, bx, by;
  logic signed [CB:0] dx_c, dy_c;
  logic signed [10:0] dz_c, bm_c, um_c;
  logic signed [21:0] pb_c;

  assign ux   = CB'($unsigned(in_data.ue_x));
  assign uy   = CB'($unsigned(in_data.ue_y));
  assign bx   = CB'($unsigned(in_data.bs_x));
  assign by   = CB'($unsigned(in_data.bs_y));
  assign dx_c = $signed({ux[CB-1], ux}) - $signed({bx[CB-1], bx});
  assign dy_c = $signed({uy[CB-1], uy}) - $signed({by[CB-1], by});
  assign dz_c = $signed({1'b0, in_data.bs_z}) - $signed({1'b0, in_data.ue_z});
  assign bm_c = $signed({1'b0, in_data.bs_z}) - 11'sd10;
  assign um_c = $signed({1'b0, in_data.ue_z}) - 11'sd10;
  assign pb_c = bm_c * um_c;

  logic signed [CB:0] dx1, dy1;
  logic signed [10:0] dz1, bm1, um1;
  logic signed [21:0] pb1;
  logic [9:0]         car1;
  logic               los1, bad1;

  always_ff @(posedge clk) begin
    if (adv) begin
      dx1  <= dx_c;
      dy1  <= dy_c;
      dz1  <= dz_c;
      bm1  <= bm_c;
      um1  <= um_c;
      pb1  <= pb_c;
      car1 <= car;
      los1 <= in_data.line_of_sight;
      bad1 <= (in_data.bs_z <= 10'd10) || (in_data.ue_z <= 10'd10);
    end
  end

  // stage 2: squares and breakpoint product
  logic signed [2*CB+1:0] sqx_c, sqy_c;
  logic signed [21:0]     sqz_c;
  logic signed [32:0]     p_c;

  assign sqx_c = dx1 * dx1;
  assign sqy_c = dy1 * dy1;
  assign sqz_c = dz1 * dz1;
  assign p_c   = pb1 * $signed({1'b0, car1});

  logic [2*CB-1:0]    sx2, sy2;
  logic [19:0]        sz2;
  logic signed [32:0] p2;
  logic [9:0]         bm2, um2, car2;
  logic               los2, bad2;

  always_ff @(posedge clk) begin
    if (adv) begin
      sx2  <= sqx_c[2*CB-1:0];
      sy2  <= sqy_c[2*CB-1:0];
      sz2  <= sqz_c[19:0];
      p2   <= p_c;
      bm2  <= bm1[9:0];
      um2  <= um1[9:0];
      car2 <= car1;
      los2 <= los1;
      bad2 <= bad1;
    end
  end

  // stage 3: squared distance, squared breakpoint term
  logic signed [65:0] psq_c;
  assign psq_c = p2 * p2;

  logic [D2W-1:0] d2_3;
  logic [63:0]    psq3;
  logic           ppos3;
  logic [9:0]     bm3, um3, car3;
  logic           los3, bad3;

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_3  <= D2W'(sx2) + D2W'(sy2) + D2W'(sz2);
      psq3  <= psq_c[63:0];
      ppos3 <= !p2[32] && (p2 != '0);
      bm3   <= bm2;
      um3   <= um2;
      car3  <= car2;
      los3  <= los2;
      bad3  <= bad2;
    end
  end

  // stage 4: scaled distance and range flags
  logic [D2W-1:0] d2_4;
  logic [63:0]    m5_4, psq4;
  logic           ppos4, gem4, ltl4, ltn4;
  logic [9:0]     bm4, um4, car4;
  logic           los4, bad4;

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_4  <= d2_3;
      m5_4  <= 64'(d2_3) * upl_pkg::BP_SCALE;
      psq4  <= psq3;
      ppos4 <= ppos3;
      gem4  <= 64'(d2_3) >= upl_pkg::D2_MIN;
      ltl4  <= 64'(d2_3) <  upl_pkg::D2_LOS_MAX;
      ltn4  <= 64'(d2_3) <  upl_pkg::D2_NLOS_MAX;
      bm4   <= bm3;
      um4   <= um3;
      car4  <= car3;
      los4  <= los3;
      bad4  <= bad3;
    end
  end

  // stage 5: breakpoint compare
  logic [D2W-1:0] d2_5;
  side_t          side5;

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_5           <= d2_4;
      side5.los      <= los4;
      side5.bad_h    <= bad4;
      side5.below_bp <= ppos4 && (m5_4 < psq4);
      side5.ge_min   <= gem4;
      side5.lt_los   <= ltl4;
      side5.lt_nlos  <= ltn4;
      side5.bm       <= bm4;
      side5.um       <= um4;
      side5.car      <= car4;
    end
  end

  // square root, side data delayed alongside
  logic [SRW-1:0] root;
  side_t          sd_a [SRW];
  side_t          sd_b [LAT_LOG];

  upl_sqrt #(.N(SQN)) u_sqrt (
    .clk (clk),
    .en  (adv),
    .x   ({d2_5, 8'b0}),
    .y   (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_a[0] <= side5;
      for (int k = 1; k < SRW; k++) sd_a[k] <= sd_a[k-1];
      sd_b[0] <= sd_a[SRW-1];
      for (int k = 1; k < LAT_LOG; k++) sd_b[k] <= sd_b[k-1];
    end
  end

  logic [upl_pkg::LOG_W-1:0] ldr, lbr, lmr, lfr;

  upl_log10 #(.XW(SRW), .FB(LOG_TABLE_BITS)) u_log_d (
    .clk (clk), .en (adv), .x (root), .y (ldr)
  );
  upl_log10 #(.XW(10), .FB(LOG_TABLE_BITS)) u_log_b (
    .clk (clk), .en (adv), .x (sd_a[SRW-1].bm), .y (lbr)
  );
  upl_log10 #(.XW(10), .FB(LOG_TABLE_BITS)) u_log_m (
    .clk (clk), .en (adv), .x (sd_a[SRW-1].um), .y (lmr)
  );
  upl_log10 #(.XW(10), .FB(LOG_TABLE_BITS)) u_log_f (
    .clk (clk), .en (adv), .x (sd_a[SRW-1].car), .y (lfr)
  );

  // back 1: offsets, branch and coefficients
  side_t              sb;
  logic [2:0]         reg_c;
  logic signed [9:0]  ca_c, cf_c, cb_c;
  logic signed [35:0] ck_c;

  assign sb = sd_b[LAT_LOG-1];

  always_comb begin
    reg_c = upl_pkg::REG_RANGE;
    ca_c  = '0;
    cf_c  = '0;
    cb_c  = '0;
    ck_c  = '0;
    if (sb.los) begin
      if (sb.ge_min && sb.below_bp) begin
        reg_c = upl_pkg::REG_LOS_NEAR;
        ca_c  = 10'sd220;
        cf_c  = 10'sd200;
        ck_c  = upl_pkg::K_NEAR;
      end else if (!sb.below_bp && sb.lt_los) begin
        if (sb.bad_h) begin
          reg_c = upl_pkg::REG_HEIGHT;
        end else begin
          reg_c = upl_pkg::REG_LOS_FAR;
          ca_c  = 10'sd400;
          cf_c  = 10'sd20;
          cb_c  = -10'sd180;
          ck_c  = upl_pkg::K_FAR;
        end
      end
    end else if (sb.ge_min && sb.lt_nlos) begin
      reg_c = upl_pkg::REG_NLOS;
      ca_c  = 10'sd367;
      cf_c  = 10'sd260;
      ck_c  = upl_pkg::K_NLOS;
    end
  end

  logic [2:0]         reg1;
  logic signed [23:0] ld1, lf1, lbm1;
  logic signed [9:0]  ca1, cf1, cb1;
  logic signed [35:0] ck1;

  always_ff @(posedge clk) begin
    if (adv) begin
      reg1 <= reg_c;
      ld1  <= $signed({2'b0, ldr}) - upl_pkg::OFS_D;
      lf1  <= $signed({2'b0, lfr}) - upl_pkg::OFS_F;
      lbm1 <= $signed({2'b0, lbr}) + $signed({2'b0, lmr}) - upl_pkg::OFS_BM;
      ca1  <= ca_c;
      cf1  <= cf_c;
      cb1  <= cb_c;
      ck1  <= ck_c;
    end
  end

  // back 2: weighted terms
  logic [2:0]         reg2;
  logic signed [35:0] ta2, tf2, tb2, ck2;
  logic signed [35:0] ta_c, tf_c, tb_c;

  assign ta_c = ld1 * ca1;
  assign tf_c = lf1 * cf1;
  assign tb_c = lbm1 * cb1;

  always_ff @(posedge clk) begin
    if (adv) begin
      reg2 <= reg1;
      ta2  <= ta_c;
      tf2  <= tf_c;
      tb2  <= tb_c;
      ck2  <= ck1;
    end
  end

  // back 3: sum
  logic [2:0]         reg3;
  logic signed [35:0] sum3;

  always_ff @(posedge clk) begin
    if (adv) begin
      reg3 <= reg2;
      sum3 <= ta2 + tf2 + tb2 + ck2;
    end
  end

  // back 4: round, divide by 512, saturation test
  logic signed [35:0] qf_c;
  assign qf_c = (sum3 + upl_pkg::DIV_RND) >>> 9;

  logic [2:0]  reg4;
  logic        pos4, sat4;
  logic [18:0] q4;

  always_ff @(posedge clk) begin
    if (adv) begin
      reg4 <= reg3;
      pos4 <= sum3 > 36'sd0;
      sat4 <= qf_c >= upl_pkg::SAT_Q;
      q4   <= qf_c[18:0];
    end
  end

  // back 5: divide by 5 through the reciprocal
  logic [2:0]  reg5;
  logic        pos5, sat5;
  logic [40:0] qm5;

  always_ff @(posedge clk) begin
    if (adv) begin
      reg5 <= reg4;
      pos5 <= pos4;
      sat5 <= sat4;
      qm5  <= 41'(q4) * 41'(upl_pkg::RECIP5);
    end
  end

  // back 6: final select
  upl_pkg::upl_out_t res6;

  always_ff @(posedge clk) begin
    if (adv) begin
      res6.region <= reg5;
      if (!pos5) begin
        res6.loss_db_q8 <= '0;
      end else if (sat5) begin
        res6.loss_db_q8 <= 16'hFFFF;
      end else begin
        res6.loss_db_q8 <= qm5[39:24];
      end
    end
  end

  // output queue
  assign push      = adv && vld[NST-1];
  assign out_valid = cnt != 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_data  = f0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) f0 <= res6;
        else             f1 <= res6;
      end
      2'b01: begin
        f0 <= f1;
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          f0 <= res6;
        end else begin
          f0 <= f1;
          f1 <= res6;
        end
      end
      default: begin
        f0 <= f0;
      end
    endcase
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> cnt != 2'd2) else $error("push into full output queue");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld)) else $error("pipeline moved during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    acc |=> vld[0]) else $error("accepted request not in first stage");

  a_zero_loss: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.region == upl_pkg::REG_RANGE ||
                  out_data.region == upl_pkg::REG_HEIGHT)
    |-> out_data.loss_db_q8 == 16'd0) else $error("nonzero loss on invalid region");

endmodule
`default_nettype wire

FILE: tb/umi_path_loss_calc_test.sv
// Testbench for umi_path_loss_calc: directed and random requests checked against a predictor.
`default_nettype none
module umi_path_loss_calc_test;

  localparam longint unsigned LOG10_2_SCALED = 64'd5050445;
  localparam longint LG_160 = 144449;
  localparam longint LG_ONE = 65536;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  upl_pkg::upl_in_t in_data;
  logic out_valid;
  logic out_ready;
  upl_pkg::upl_out_t out_data;
  logic cfg_we;
  logic [9:0] cfg_wdata;

  upl_pkg::upl_out_t loss_expected[$];
  logic [9:0] carrier;
  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int sent;
  int region_seen[5];

  umi_path_loss_calc dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // log10 of an integer, signed Q16, 8 fraction bits of log2
  function automatic longint log10_q16(longint unsigned x);
    int e;
    longint unsigned m, frac, l2;
    if (x == 0) x = 1;
    e = 63;
    while (x[e] == 1'b0) e--;
    m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
    frac = 0;
    for (int i = 0; i < 8; i++) begin
      m = (m * m) >> 31;
      frac <<= 1;
      if ((m >> 32) != 0) begin
        frac |= 1;
        m >>= 1;
      end
    end
    l2 = (longint'(e) << 8) | frac;
    return longint'((l2 * LOG10_2_SCALED) >> 16);
  endfunction

  function automatic upl_pkg::upl_out_t path_loss(upl_pkg::upl_in_t r);
    longint dx, dy, dz, uz, bz, p, ld, lf, lb, lm, sum;
    longint unsigned d2, loss;
    logic below_bp;
    upl_pkg::upl_out_t o;
    dx = longint'(r.ue_x) - longint'(r.bs_x);
    dy = longint'(r.ue_y) - longint'(r.bs_y);
    uz = r.ue_z;
    bz = r.bs_z;
    dz = bz - uz;
    d2 = dx * dx + dy * dy + dz * dz;
    p = (bz - 10) * (uz - 10) * longint'(carrier);
    below_bp = (p > 0) && ((64'd5625 * d2) < (64'(p) * 64'(p)));
    ld = log10_q16(isqrt(d2 << 8)) - LG_160;
    lf = log10_q16(carrier) - 2 * LG_ONE;
    sum = 0;
    if (r.line_of_sight) begin
      if (d2 >= 10000 && below_bp) begin
        o.region = upl_pkg::REG_LOS_NEAR;
        sum = 220 * ld + 200 * lf + 280 * LG_ONE;
      end else if (!below_bp && d2 < 64'd2500000000) begin
        if (bz <= 10 || uz <= 10) begin
          o.region = upl_pkg::REG_HEIGHT;
        end else begin
          lb = log10_q16(bz - 10) - LG_ONE;
          lm = log10_q16(uz - 10) - LG_ONE;
          o.region = upl_pkg::REG_LOS_FAR;
          sum = 400 * ld - 180 * lb - 180 * lm + 20 * lf + 78 * LG_ONE;
        end
      end else begin
        o.region = upl_pkg::REG_RANGE;
      end
    end else begin
      if (d2 >= 10000 && d2 < 64'd400000000) begin
        o.region = upl_pkg::REG_NLOS;
        sum = 367 * ld + 260 * lf + 227 * LG_ONE;
      end else begin
        o.region = upl_pkg::REG_RANGE;
      end
    end
    loss = 0;
    if (sum > 0) begin
      loss = (64'(sum) + 1280) / 2560;
      if (loss > 65535) loss = 65535;
    end
    o.loss_db_q8 = loss[15:0];
    return o;
  endfunction

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(negedge clk) begin
    upl_pkg::upl_out_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (loss_expected.size() == 0) begin
        $error("result with nothing expected: loss %0d region %0d",
               out_data.loss_db_q8, out_data.region);
        errors++;
      end else begin
        exp_r = loss_expected.pop_front();
        if (out_data.loss_db_q8 !== exp_r.loss_db_q8) begin
          $error("loss_db_q8 expected %0d actual %0d", exp_r.loss_db_q8, out_data.loss_db_q8);
          errors++;
        end
        if (out_data.region !== exp_r.region) begin
          $error("region expected %0d actual %0d", exp_r.region, out_data.region);
          errors++;
        end
        if (exp_r.region <= upl_pkg::REG_HEIGHT) region_seen[exp_r.region]++;
      end
    end
  end

  task automatic send_req(upl_pkg::upl_in_t r);
    logic hs;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do begin
      @(negedge clk);
      hs = in_ready;
      @(posedge clk);
    end while (!hs);
    loss_expected.push_back(path_loss(r));
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (loss_expected.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_carrier(logic [9:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    carrier = v;
  endtask

  function automatic upl_pkg::upl_in_t mk(int ux, int uy, int uz, int bx, int by, int bz,
                                          bit los);
    upl_pkg::upl_in_t r;
    r.ue_x = 16'(ux); r.ue_y = 16'(uy); r.ue_z = 10'(uz);
    r.bs_x = 16'(bx); r.bs_y = 16'(by); r.bs_z = 10'(bz);
    r.line_of_sight = los;
    return r;
  endfunction

  function automatic upl_pkg::upl_in_t rand_req();
    upl_pkg::upl_in_t r;
    int span;
    r = upl_pkg::upl_in_t'($bits(upl_pkg::upl_in_t)'({$urandom, $urandom, $urandom}));
    case ($urandom_range(3))
      0: span = 0;
      1: span = 30000;
      2: span = 3000;
      default: span = 400;
    endcase
    if (span != 0) begin
      r.ue_x = 16'($urandom_range(2 * span) - span);
      r.ue_y = 16'($urandom_range(2 * span) - span);
      r.bs_x = 16'($urandom_range(2 * span) - span);
      r.bs_y = 16'($urandom_range(2 * span) - span);
    end
    if ($urandom_range(3) != 0) begin
      r.ue_z = 10'($urandom_range(300, 5));
      r.bs_z = 10'($urandom_range(400, 5));
    end
    return r;
  endfunction

  task automatic test_directed();
    send_req(mk(-32768, -32768, 0, 32767, 32767, 1023, 1));
    send_req(mk(32767, 32767, 1023, -32768, -32768, 0, 0));
    send_req(mk(0, 0, 15, 500, 0, 100, 1));
    send_req(mk(0, 0, 15, 20000, 0, 100, 1));
    send_req(mk(0, 0, 15, 20000, 0, 100, 0));
    send_req(mk(0, 0, 15, 50, 0, 100, 0));
    send_req(mk(0, 0, 15, 50, 0, 100, 1));
    send_req(mk(0, 0, 15, 25000, 0, 100, 0));
    send_req(mk(0, 0, 10, 3000, 0, 100, 1));
    send_req(mk(0, 0, 100, 3000, 0, 10, 1));
    send_req(mk(0, 0, 5, 300, 0, 100, 1));
    send_req(mk(0, 0, 5, 300, 0, 3, 1));
    send_req(mk(0, 0, 5, 20000, 0, 3, 1));
    send_req(mk(0, 0, 1023, 100, 0, 1023, 1));
    send_req(mk(-32768, 32767, 11, 32767, -32768, 11, 1));
    send_req(mk(0, 0, 0, 0, 0, 0, 0));
    send_req(mk(0, 0, 0, 0, 0, 0, 1));
    send_req(mk(1000, -1000, 11, -1000, 1000, 11, 1));
    send_req(mk(100, 0, 20, 0, 0, 20, 0));
    send_req(mk(0, 0, 20, 4999, 0, 20, 1));
  endtask

  task automatic test_carrier_sweep();
    logic [9:0] vals[6] = '{10'd0, 10'd50, 10'd600, 10'd1023, 10'd1, 10'd250};
    foreach (vals[i]) begin
      write_carrier(vals[i]);
      repeat (50) send_req(rand_req());
    end
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int n);
    drain();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_req(rand_req());
  endtask

  task automatic test_pause_until_empty();
    repeat (20) send_req(rand_req());
    drain();
    repeat (20) send_req(rand_req());
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    carrier = upl_pkg::CAR_RESET;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_carrier_sweep();
    test_random_phase(0, 0, 330);
    test_random_phase(72, 0, 330);
    test_random_phase(0, 72, 330);
    test_random_phase(38, 38, 290);
    test_pause_until_empty();
    drain();
    $display("Sent %0d requests over six carrier settings and four handshake idle mixes.", sent);
    $display("Results per region near/far/nlos/range/height: %0d %0d %0d %0d %0d",
             region_seen[0], region_seen[1], region_seen[2], region_seen[3], region_seen[4]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
